// ----- hdl/mexp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_pkg: shared types, constants and microprogram
// Field widths, control word layout and the sequencer program of the
// modular exponentiation core.
// ----------------------------------------------------------------------------
package mexp_pkg;

  // Width of every operand and residue field on the channels
  localparam int FIELD_BITS = 63;

  // Default operand width used inside the datapath
  localparam int OPERAND_BITS_DEF = 63;

  // Program counter width and step addresses
  localparam int PC_BITS = 4;

  localparam logic [PC_BITS-1:0] PC_WAIT  = 4'd0;
  localparam logic [PC_BITS-1:0] PC_CHK   = 4'd1;
  localparam logic [PC_BITS-1:0] PC_LDB   = 4'd2;
  localparam logic [PC_BITS-1:0] PC_MULB  = 4'd3;
  localparam logic [PC_BITS-1:0] PC_LDSQ  = 4'd4;
  localparam logic [PC_BITS-1:0] PC_MULSQ = 4'd5;
  localparam logic [PC_BITS-1:0] PC_LDM   = 4'd6;
  localparam logic [PC_BITS-1:0] PC_MULM  = 4'd7;
  localparam logic [PC_BITS-1:0] PC_NEXT  = 4'd8;
  localparam logic [PC_BITS-1:0] PC_FIN   = 4'd9;
  localparam logic [PC_BITS-1:0] PC_BACK  = 4'd10;

  // Operand selection when a modular product is started (a, b)
  typedef enum logic [1:0] {
    LD_NONE,
    LD_R_BASE,   // a = r,    b = base
    LD_R_R,      // a = r,    b = r
    LD_BRED_R    // a = bred, b = r
  } load_sel_t;

  // Write-back target; ONE is immediate, the others on the last product step
  typedef enum logic [1:0] {
    WB_NONE,
    WB_ONE,
    WB_BRED,
    WB_R
  } wb_sel_t;

  // Jump conditions
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_MOD_ZERO,
    C_MUL_MORE,
    C_BIT_ZERO,
    C_EXP_MORE,
    C_OUT_BUSY
  } cond_t;

  // One control word of the microprogram
  typedef struct packed {
    logic               wait_in;
    load_sel_t          load;
    logic               mul_step;
    wb_sel_t            wb;
    logic               exp_step;
    logic               emit;
    cond_t              cond;
    logic [PC_BITS-1:0] target;
  } ucw_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic in_fire;
    logic mod_zero;
    logic mul_more;
    logic exp_bit;
    logic exp_more;
    logic out_busy;
  } mexp_stat_t;

  // Build a control word
  function automatic ucw_t uword(input logic wait_in, input load_sel_t load,
                                 input logic mul_step, input wb_sel_t wb,
                                 input logic exp_step, input logic emit,
                                 input cond_t cond, input logic [PC_BITS-1:0] target);
    ucw_t w;
    w.wait_in  = wait_in;
    w.load     = load;
    w.mul_step = mul_step;
    w.wb       = wb;
    w.exp_step = exp_step;
    w.emit     = emit;
    w.cond     = cond;
    w.target   = target;
    return w;
  endfunction

  // Microprogram ROM
  function automatic ucw_t ucode_word(input logic [PC_BITS-1:0] pc);
    ucw_t w;
    unique case (pc)
      PC_WAIT:  w = uword(1'b1, LD_NONE,   1'b0, WB_NONE, 1'b0, 1'b0, C_NO_IN,    PC_WAIT);
      PC_CHK:   w = uword(1'b0, LD_NONE,   1'b0, WB_ONE,  1'b0, 1'b0, C_MOD_ZERO, PC_FIN);
      PC_LDB:   w = uword(1'b0, LD_R_BASE, 1'b0, WB_NONE, 1'b0, 1'b0, C_NEVER,    PC_WAIT);
      PC_MULB:  w = uword(1'b0, LD_NONE,   1'b1, WB_BRED, 1'b0, 1'b0, C_MUL_MORE, PC_MULB);
      PC_LDSQ:  w = uword(1'b0, LD_R_R,    1'b0, WB_NONE, 1'b0, 1'b0, C_NEVER,    PC_WAIT);
      PC_MULSQ: w = uword(1'b0, LD_NONE,   1'b1, WB_R,    1'b0, 1'b0, C_MUL_MORE, PC_MULSQ);
      PC_LDM:   w = uword(1'b0, LD_BRED_R, 1'b0, WB_NONE, 1'b0, 1'b0, C_BIT_ZERO, PC_NEXT);
      PC_MULM:  w = uword(1'b0, LD_NONE,   1'b1, WB_R,    1'b0, 1'b0, C_MUL_MORE, PC_MULM);
      PC_NEXT:  w = uword(1'b0, LD_R_R,    1'b0, WB_NONE, 1'b1, 1'b0, C_EXP_MORE, PC_MULSQ);
      PC_FIN:   w = uword(1'b0, LD_NONE,   1'b0, WB_NONE, 1'b0, 1'b1, C_OUT_BUSY, PC_FIN);
      PC_BACK:  w = uword(1'b0, LD_NONE,   1'b0, WB_NONE, 1'b0, 1'b0, C_ALWAYS,   PC_WAIT);
      default:  w = uword(1'b0, LD_NONE,   1'b0, WB_NONE, 1'b0, 1'b0, C_ALWAYS,   PC_WAIT);
    endcase
    return w;
  endfunction

endpackage

// ----- hdl/mexp_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_in_if: operand channel
// Valid/ready channel carrying base, exponent and modulus.
// ----------------------------------------------------------------------------
interface mexp_in_if import mexp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [FIELD_BITS-1:0] base_value;
  logic [FIELD_BITS-1:0] power;
  logic [FIELD_BITS-1:0] modulus;

  modport source (output valid, output base_value, output power, output modulus,
                  input ready);
  modport sink   (input valid, input base_value, input power, input modulus,
                  output ready);
endinterface

// ----- hdl/mexp_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_out_if: result channel
// Valid/ready channel carrying the residue and the bad modulus flag.
// ----------------------------------------------------------------------------
interface mexp_out_if import mexp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [FIELD_BITS-1:0] residue;
  logic                  bad_modulus;

  modport source (output valid, output residue, output bad_modulus, input ready);
  modport sink   (input valid, input residue, input bad_modulus, output ready);
endinterface

// ----- hdl/mexp_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_sequencer: microprogram sequencer
// Step counter over the control ROM with conditional jumps on datapath status.
// ----------------------------------------------------------------------------
module mexp_sequencer import mexp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  mexp_stat_t stat,
  output ucw_t       cw
);

  logic [PC_BITS-1:0] pc;
  logic [PC_BITS-1:0] pc_next;
  logic               take;

  // Fetch the current control word
  always_comb begin
    cw = ucode_word(pc);
  end

  // Evaluate the jump condition
  always_comb begin
    unique case (cw.cond)
      C_NEVER:    take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NO_IN:    take = !stat.in_fire;
      C_MOD_ZERO: take = stat.mod_zero;
      C_MUL_MORE: take = stat.mul_more;
      C_BIT_ZERO: take = !stat.exp_bit;
      C_EXP_MORE: take = stat.exp_more;
      C_OUT_BUSY: take = stat.out_busy;
      default:    take = 1'b1;
    endcase
    pc_next = take ? cw.target : pc + 1'b1;
  end

  // Advance the step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

  // An accepted word always leads to the modulus check
  a_fire_to_chk: assert property (@(posedge clk) disable iff (rst)
    stat.in_fire |=> pc == PC_CHK)
    else $error("accepted word did not advance to modulus check");

  // Input is only taken in the wait step
  a_fire_in_wait: assert property (@(posedge clk) disable iff (rst)
    stat.in_fire |-> pc == PC_WAIT)
    else $error("input accepted outside the wait step");

endmodule

// ----- hdl/mexp_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_datapath: operand registers and doubling modular multiplier
// Captures a word, runs one shift-add-reduce step per cycle under microcode
// control and holds the result in an output register.
// ----------------------------------------------------------------------------
module mexp_datapath import mexp_pkg::*; #(
  parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  ucw_t        cw,
  output mexp_stat_t  stat,
  mexp_in_if.sink     in_ch,
  mexp_out_if.source  out_ch
);

  localparam int N        = OPERAND_BITS;
  localparam int CNT_BITS = $clog2(N + 1);

  logic [N-1:0]        m;
  logic [N-1:0]        base;
  logic [N-1:0]        exp_sr;
  logic [CNT_BITS-1:0] exp_cnt;
  logic [N-1:0]        r;
  logic [N-1:0]        bred;
  logic [N-1:0]        acc;
  logic [N-1:0]        mcand;
  logic [N-1:0]        mplier;
  logic [CNT_BITS-1:0] mul_cnt;
  logic                res_valid;
  logic [N-1:0]        residue;
  logic                bad;

  logic                in_fire;
  logic                out_busy;
  logic                mod_zero;
  logic [N-1:0]        one;
  logic [N+1:0]        sum;
  logic [N+1:0]        m1;
  logic [N+1:0]        m2;
  logic [N+1:0]        red;
  logic [N-1:0]        acc_next;

  // Handshake and status; refuse words while reset is held
  assign in_ch.ready = cw.wait_in && !rst;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_busy    = res_valid && !out_ch.ready;
  assign mod_zero    = (m == '0);
  assign one         = (m == N'(1)) ? '0 : N'(1);

  always_comb begin
    stat.in_fire  = in_fire;
    stat.mod_zero = mod_zero;
    stat.mul_more = (mul_cnt != CNT_BITS'(1));
    stat.exp_bit  = exp_sr[N-1];
    stat.exp_more = (exp_cnt != CNT_BITS'(1));
    stat.out_busy = out_busy;
  end

  // One Horner step: acc = 2*acc + bit*mcand, then reduce (sum < 3m)
  always_comb begin
    m1  = {2'b00, m};
    m2  = {1'b0, m, 1'b0};
    sum = {1'b0, acc, 1'b0} + (mplier[N-1] ? {2'b00, mcand} : '0);
    priority if (sum >= m2) begin
      red = sum - m2;
    end else if (sum >= m1) begin
      red = sum - m1;
    end else begin
      red = sum;
    end
    acc_next = red[N-1:0];
  end

  // Operand capture, product loop, exponent walk
  always_ff @(posedge clk) begin
    if (in_fire) begin
      base    <= in_ch.base_value[N-1:0];
      exp_sr  <= in_ch.power[N-1:0];
      m       <= in_ch.modulus[N-1:0];
      exp_cnt <= CNT_BITS'(N);
    end
    if (cw.wb == WB_ONE) begin
      r <= one;
    end
    unique case (cw.load)
      LD_NONE: begin
      end
      LD_R_BASE: begin
        mcand  <= r;
        mplier <= base;
      end
      LD_R_R: begin
        mcand  <= r;
        mplier <= r;
      end
      LD_BRED_R: begin
        mcand  <= bred;
        mplier <= r;
      end
      default: begin
      end
    endcase
    if (cw.load != LD_NONE) begin
      acc     <= '0;
      mul_cnt <= CNT_BITS'(N);
    end
    if (cw.mul_step) begin
      acc     <= acc_next;
      mplier  <= {mplier[N-2:0], 1'b0};
      mul_cnt <= mul_cnt - 1'b1;
      // write back on the last step
      if (mul_cnt == CNT_BITS'(1)) begin
        if (cw.wb == WB_BRED) begin
          bred <= acc_next;
        end
        if (cw.wb == WB_R) begin
          r <= acc_next;
        end
      end
    end
    if (cw.exp_step) begin
      exp_sr  <= {exp_sr[N-2:0], 1'b0};
      exp_cnt <= exp_cnt - 1'b1;
    end
    if (cw.emit && !out_busy) begin
      residue <= mod_zero ? '0 : r;
      bad     <= mod_zero;
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cw.emit && !out_busy) begin
      res_valid <= 1'b1;
    end else if (out_ch.ready) begin
      res_valid <= 1'b0;
    end
  end

  assign out_ch.valid       = res_valid;
  assign out_ch.residue     = FIELD_BITS'(residue);
  assign out_ch.bad_modulus = bad;

  // Accumulator stays reduced through a product
  a_acc_reduced: assert property (@(posedge clk) disable iff (rst)
    cw.mul_step && !mod_zero |=> acc < m)
    else $error("accumulator left the residue range");

  // A started product begins from zero
  a_load_clears: assert property (@(posedge clk) disable iff (rst)
    cw.load != LD_NONE |=> acc == '0)
    else $error("product load did not clear the accumulator");

  // Error results carry a zero residue
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && bad |-> residue == '0)
    else $error("bad modulus result with nonzero residue");

endmodule

// ----- hdl/modular_exponentiation_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation_core: base^power mod modulus
// Square-and-multiply exponentiation driven by a microcoded sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries base_value, power and modulus; a word is taken when valid
//          and ready are both high. Only the low OPERAND_BITS bits are used.
//   out_ch carries residue and bad_modulus, one word per input word.
//   Ready on in_ch is high only while the sequencer waits for work, so one
//   exponentiation runs at a time. Every modular product runs one
//   shift-add-reduce step per cycle in a single shared multiplier. A zero
//   modulus skips the products and returns residue 0 with bad_modulus set.
//   The result sits in an output register; the next word is accepted while
//   it waits. If the receiver stalls, the following result holds the
//   sequencer in its final step until the register frees.
//   Reset (rst, synchronous) returns the sequencer to its wait step and
//   empties the output register.
// ----------------------------------------------------------------------------
module modular_exponentiation_core import mexp_pkg::*; #(
  parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  mexp_in_if.sink    in_ch,
  mexp_out_if.source out_ch
);

  ucw_t       cw;
  mexp_stat_t stat;

  // Control: step counter over the microprogram
  mexp_sequencer u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cw   (cw)
  );

  // Datapath: operands, multiplier and output register
  mexp_datapath #(
    .OPERAND_BITS (OPERAND_BITS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cw     (cw),
    .stat   (stat),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule
